@@ hw/rtl/slcfp_pkg.sv @@
// ----------------------------------------------------------------------------
// slcfp_pkg: shared types and constants for the sync/length/CRC-8 parser
// Result kinds, register indexes, reset values and the CRC-8 byte update.
// ----------------------------------------------------------------------------
package slcfp_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 32;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_DATA   = 2'd0,
        KIND_GOOD   = 2'd1,
        KIND_CRCERR = 2'd2,
        KIND_REJECT = 2'd3
    } kind_t;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd2;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;
    localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RST = 8'd64;

    // Reflected CRC-8 polynomial
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;

    // Receive phases, one-hot
    typedef enum logic [5:0] {
        PH_SYNC1   = 6'b000001,
        PH_SYNC2   = 6'b000010,
        PH_FUNC    = 6'b000100,
        PH_LEN     = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_CRC     = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [COUNT_W-1:0] invalid_count;
        logic [COUNT_W-1:0] crc_error_count;
        logic [COUNT_W-1:0] good_count;
        logic [BYTE_W-1:0]  payload_length;
        logic [BYTE_W-1:0]  function_code;
        logic [BYTE_W-1:0]  data_byte;
        kind_t              kind;
    } result_t;

    // One byte through the LSB-first CRC-8 shift register
    function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/sync_length_crc8_frame_parser.sv @@
// ----------------------------------------------------------------------------
// sync_length_crc8_frame_parser: two-sync-byte, length-framed receiver
// Hunts sync bytes, reads function and length, streams payload, checks CRC-8.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one received byte per word. m_* carries one result word:
//   m_tuser is the kind (payload byte, frame good, CRC error, length
//   rejected), m_tdata the byte, frame header and the three frame counters.
//   Sync bytes, function bytes and accepted length bytes produce no result;
//   every payload byte, every CRC byte and every rejected length produce one.
//   cfg_* writes sync_first (0), sync_second (1), max_payload (2); other
//   indexes are ignored. cfg_ready is always high; write only while idle.
// Timing:
//   One byte per cycle while s_tready is high; each result is registered
//   into the output register or the skid stage when its byte is taken. The
//   phase update and the CRC step are combinational before those registers.
// Reset and stall:
//   Synchronous reset restores the register defaults, returns to sync hunt
//   and clears the counters. A stalled receiver first fills a one-word skid
//   stage behind the output register; s_tready drops only while that stage
//   holds a word.
// ----------------------------------------------------------------------------
module sync_length_crc8_frame_parser
    import slcfp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,     // [7:0] rx_byte

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] data_byte, [15:8] function_code, [23:16] payload_length,
    // [55:24] good_count, [87:56] crc_error_count, [119:88] invalid_count
    output logic [119:0]         m_tdata,
    output logic [KIND_W-1:0]    m_tuser,     // [1:0] kind

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data
);

    logic [BYTE_W-1:0]  sync_first_reg, sync_second_reg, max_payload_reg;

    phase_t             phase_reg, phase_next;
    logic [BYTE_W-1:0]  bytes_left_reg, bytes_left_next;
    logic [BYTE_W-1:0]  func_reg, func_next;
    logic [BYTE_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0]  crc_reg, crc_next;
    logic [COUNT_W-1:0] good_reg, good_next;
    logic [COUNT_W-1:0] crcerr_reg, crcerr_next;
    logic [COUNT_W-1:0] invalid_reg, invalid_next;

    logic               res_valid;
    result_t            res;

    logic               out_valid_reg, skid_valid_reg;
    result_t            out_reg, skid_reg;

    logic               in_fire;
    logic [BYTE_W-1:0]  b;
    logic [BYTE_W-1:0]  crc_step;
    logic [BYTE_W-1:0]  left_dec;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign in_fire   = s_tvalid && s_tready;
    assign b         = s_tdata;

    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_reg.kind;
    assign m_tdata   = {out_reg.invalid_count, out_reg.crc_error_count, out_reg.good_count,
                        out_reg.payload_length, out_reg.function_code, out_reg.data_byte};

    assign crc_step = crc8_update((phase_reg == PH_FUNC) ? '0 : crc_reg, b);
    assign left_dec = (bytes_left_reg != '0) ? bytes_left_reg - 1'b1 : bytes_left_reg;

    always_comb begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        func_next       = func_reg;
        len_next        = len_reg;
        crc_next        = crc_reg;
        good_next       = good_reg;
        crcerr_next     = crcerr_reg;
        invalid_next    = invalid_reg;
        res_valid       = 1'b0;
        res.kind        = KIND_DATA;
        res.data_byte   = '0;

        case (phase_reg)
            PH_SYNC2: begin
                if (b == sync_second_reg) begin
                    phase_next = PH_FUNC;
                end else if (b == sync_first_reg) begin
                    phase_next = PH_SYNC2;
                end else begin
                    phase_next = PH_SYNC1;
                end
            end
            PH_FUNC: begin
                func_next  = b;
                crc_next   = crc_step;
                phase_next = PH_LEN;
            end
            PH_LEN: begin
                len_next = b;
                crc_next = crc_step;
                if (b > max_payload_reg) begin
                    invalid_next = invalid_reg + 1'b1;
                    phase_next   = PH_SYNC1;
                    res_valid    = 1'b1;
                    res.kind     = KIND_REJECT;
                end else begin
                    bytes_left_next = b;
                    phase_next      = (b == '0) ? PH_CRC : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                crc_next        = crc_step;
                bytes_left_next = left_dec;
                if (left_dec == '0) begin
                    phase_next = PH_CRC;
                end
                res_valid     = 1'b1;
                res.kind      = KIND_DATA;
                res.data_byte = b;
            end
            PH_CRC: begin
                phase_next = PH_SYNC1;
                res_valid  = 1'b1;
                if (b == crc_reg) begin
                    good_next = good_reg + 1'b1;
                    res.kind  = KIND_GOOD;
                end else begin
                    crcerr_next  = crcerr_reg + 1'b1;
                    invalid_next = invalid_reg + 1'b1;
                    res.kind     = KIND_CRCERR;
                end
            end
            default: begin
                phase_next = (b == sync_first_reg) ? PH_SYNC2 : PH_SYNC1;
            end
        endcase

        res.function_code   = func_next;
        res.payload_length  = len_next;
        res.good_count      = good_next;
        res.crc_error_count = crcerr_next;
        res.invalid_count   = invalid_next;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
            max_payload_reg <= MAX_PAYLOAD_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                REG_SYNC_SECOND: sync_second_reg <= cfg_data;
                REG_MAX_PAYLOAD: max_payload_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Frame state, advanced on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SYNC1;
            bytes_left_reg <= '0;
            func_reg       <= '0;
            len_reg        <= '0;
            crc_reg        <= '0;
            good_reg       <= '0;
            crcerr_reg     <= '0;
            invalid_reg    <= '0;
        end else if (in_fire) begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            func_reg       <= func_next;
            len_reg        <= len_next;
            crc_reg        <= crc_next;
            good_reg       <= good_next;
            crcerr_reg     <= crcerr_next;
            invalid_reg    <= invalid_next;
        end
    end

    // Output register with one-word skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= in_fire && res_valid;
            end
        end else if (in_fire && res_valid) begin
            // hold the stalled word, park the new one
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end else if (in_fire && res_valid) begin
            skid_reg <= res;
        end
    end

endmodule
